FILE: sv/dpu_pkg.sv
package dpu_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STEP_W   = 16;
	localparam int unsigned PROD_W   = WORD_W + STEP_W + 1;
	localparam int unsigned LANES    = 3;
	localparam int unsigned TDATA_W  = 2 * WORD_W + 3 * LANES * WORD_W;
	localparam int unsigned CFG_IDX_W = 4;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_DAMPING = 4'd3;

	localparam logic [STEP_W-1:0] TIME_STEP_RST    = 16'd1049;
	localparam logic [WORD_W-1:0] GRAVITY_RST      = 32'd0;
	localparam logic [STEP_W-1:0] DRAG_FACTOR_RST  = 16'd32113;
	localparam logic [STEP_W-1:0] SPIN_DAMPING_RST = 16'd31130;

	typedef struct packed {
		logic [STEP_W-1:0] time_step;
		logic [WORD_W-1:0] gravity;
		logic [STEP_W-1:0] drag_factor;
		logic [STEP_W-1:0] spin_damping;
	} dpu_cfg_t;

	typedef logic [LANES-1:0][WORD_W-1:0] vec3_t;
	typedef logic [LANES-1:0][PROD_W-1:0] prod3_t;

	typedef struct packed {
		logic              alive;
		logic [WORD_W-1:0] age;
		logic [WORD_W-1:0] lifetime;
		vec3_t             vel;
		vec3_t             pos;
		vec3_t             spin;
	} rec_t;

	function automatic logic [WORD_W-1:0] sat32(input logic signed [WORD_W+1:0] v);
		if (v > 34'sh0_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		else if (v < -34'sh0_8000_0000)
			return 32'h8000_0000;
		else
			return v[WORD_W-1:0];
	endfunction

	// signed word times unsigned Q.16 / Q1.15 factor
	function automatic logic signed [PROD_W-1:0] mul_su(input logic signed [WORD_W-1:0] a,
			input logic [STEP_W-1:0] f);
		logic signed [STEP_W:0] fs;
		fs = {1'b0, f};
		return PROD_W'(a) * PROD_W'(fs);
	endfunction

	// floor(p / 2^15) then clamp
	function automatic logic [WORD_W-1:0] shift_sat15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		sh = p >>> 15;
		return sat32(sh[WORD_W+1:0]);
	endfunction

	// a + floor(p / 2^16), clamped
	function automatic logic [WORD_W-1:0] add_sat16(input logic signed [WORD_W-1:0] a,
			input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		logic [WORD_W+1:0] s;
		sh = p >>> 16;
		s = {{2{a[WORD_W-1]}}, a} + {sh[WORD_W], sh[WORD_W:0]};
		return sat32(s);
	endfunction

endpackage

FILE: sv/dpu_cfg_regs.sv
module dpu_cfg_regs import dpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	output dpu_cfg_t             cfg
);

	dpu_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step    <= TIME_STEP_RST;
			cfg_q.gravity      <= GRAVITY_RST;
			cfg_q.drag_factor  <= DRAG_FACTOR_RST;
			cfg_q.spin_damping <= SPIN_DAMPING_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TIME_STEP:    cfg_q.time_step    <= wr_data[STEP_W-1:0];
				REG_GRAVITY:      cfg_q.gravity      <= wr_data;
				REG_DRAG_FACTOR:  cfg_q.drag_factor  <= wr_data[STEP_W-1:0];
				REG_SPIN_DAMPING: cfg_q.spin_damping <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/debris_particle_update.sv
// data path: each input transaction passes through the stage 1 to stage 6 registers to output valid
// throughput: one particle per cycle while m_axis_tready does not hold the output; six register
// stages, built from 32x17 multiplies and 34 bit saturating adds
// reset: arst_n clears all stage valid bits and loads the configuration registers with their defaults
module debris_particle_update import dpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// age, lifetime, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, spin_x, spin_y, spin_z
	input  logic [TDATA_W-1:0]   s_axis_tdata,
	// alive
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// age_out, lifetime_out, vel_x_out .. vel_z_out, pos_x_out .. pos_z_out,
	// spin_x_out .. spin_z_out
	output logic [TDATA_W-1:0]   m_axis_tdata,
	// alive_out
	output logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	dpu_cfg_t cfg;

	assign cfg_ready = 1'b1;

	dpu_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || m_axis_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// input unpacking
	rec_t in_rec;

	always_comb begin
		in_rec.alive    = s_axis_tuser;
		in_rec.age      = s_axis_tdata[0 +: WORD_W];
		in_rec.lifetime = s_axis_tdata[WORD_W +: WORD_W];
		for (int i = 0; i < LANES; i++) begin
			in_rec.vel[i]  = s_axis_tdata[(2 + i) * WORD_W +: WORD_W];
			in_rec.pos[i]  = s_axis_tdata[(2 + LANES + i) * WORD_W +: WORD_W];
			in_rec.spin[i] = s_axis_tdata[(2 + 2 * LANES + i) * WORD_W +: WORD_W];
		end
	end

	// stage 1: age update, death test, gravity and spin products
	logic [WORD_W:0]   age_sum;
	logic [WORD_W-1:0] age_new;
	logic              dead;

	always_comb begin
		age_sum = {1'b0, in_rec.age} + {{(WORD_W + 1 - STEP_W){1'b0}}, cfg.time_step};
		age_new = age_sum[WORD_W] ? '1 : age_sum[WORD_W-1:0];
		dead    = age_new >= in_rec.lifetime;
	end

	rec_t              rec_s1, rec_s2, rec_s3, rec_s4, rec_s5;
	logic              upd_s1, upd_s2, upd_s3, upd_s4, upd_s5;
	logic [WORD_W-1:0] age_s1, age_s2, age_s3, age_s4, age_s5;
	logic [PROD_W-1:0] grav_s1;
	prod3_t            spinp_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			rec_s1  <= in_rec;
			upd_s1  <= in_rec.alive && !dead;
			age_s1  <= in_rec.alive ? age_new : in_rec.age;
			grav_s1 <= mul_su(cfg.gravity, cfg.time_step);
			for (int i = 0; i < LANES; i++)
				spinp_s1[i] <= mul_su(in_rec.spin[i], cfg.spin_damping);
		end
	end

	// stage 2: gravity into vertical velocity, spin scaling
	vec3_t vel_s2, spin_s2, spin_s3, spin_s4, spin_s5;

	always_ff @(posedge clk) begin
		if (en2) begin
			rec_s2    <= rec_s1;
			upd_s2    <= upd_s1;
			age_s2    <= age_s1;
			vel_s2[0] <= rec_s1.vel[0];
			vel_s2[1] <= add_sat16(rec_s1.vel[1], grav_s1);
			vel_s2[2] <= rec_s1.vel[2];
			for (int i = 0; i < LANES; i++)
				spin_s2[i] <= shift_sat15(spinp_s1[i]);
		end
	end

	// stage 3: drag products
	prod3_t velp_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			rec_s3  <= rec_s2;
			upd_s3  <= upd_s2;
			age_s3  <= age_s2;
			spin_s3 <= spin_s2;
			for (int i = 0; i < LANES; i++)
				velp_s3[i] <= mul_su(vel_s2[i], cfg.drag_factor);
		end
	end

	// stage 4: drag scaling
	vec3_t vel_s4, vel_s5;

	always_ff @(posedge clk) begin
		if (en4) begin
			rec_s4  <= rec_s3;
			upd_s4  <= upd_s3;
			age_s4  <= age_s3;
			spin_s4 <= spin_s3;
			for (int i = 0; i < LANES; i++)
				vel_s4[i] <= shift_sat15(velp_s3[i]);
		end
	end

	// stage 5: displacement products
	prod3_t posp_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			rec_s5  <= rec_s4;
			upd_s5  <= upd_s4;
			age_s5  <= age_s4;
			spin_s5 <= spin_s4;
			vel_s5  <= vel_s4;
			for (int i = 0; i < LANES; i++)
				posp_s5[i] <= mul_su(vel_s4[i], cfg.time_step);
		end
	end

	// stage 6: position update and final select into the output register
	rec_t out_rec;
	rec_t out_s6;

	always_comb begin
		out_rec          = rec_s5;
		out_rec.alive    = upd_s5;
		out_rec.age      = age_s5;
		if (upd_s5) begin
			out_rec.vel  = vel_s5;
			out_rec.spin = spin_s5;
			for (int i = 0; i < LANES; i++)
				out_rec.pos[i] = add_sat16(rec_s5.pos[i], posp_s5[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en6)
			out_s6 <= out_rec;
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tuser  = out_s6.alive;

	always_comb begin
		m_axis_tdata[0 +: WORD_W]      = out_s6.age;
		m_axis_tdata[WORD_W +: WORD_W] = out_s6.lifetime;
		for (int i = 0; i < LANES; i++) begin
			m_axis_tdata[(2 + i) * WORD_W +: WORD_W]             = out_s6.vel[i];
			m_axis_tdata[(2 + LANES + i) * WORD_W +: WORD_W]     = out_s6.pos[i];
			m_axis_tdata[(2 + 2 * LANES + i) * WORD_W +: WORD_W] = out_s6.spin[i];
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import dpu_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 120;
	localparam int MAX_GAP      = 24;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 76;
	localparam int N_DIRECTED   = 14;
	localparam int LANE_Y       = 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam longint U32_HI = 64'sh0_FFFF_FFFF;

	typedef struct {
		bit                     alive;
		bit        [WORD_W-1:0] age;
		bit        [WORD_W-1:0] lifetime;
		bit signed [WORD_W-1:0] vel[LANES];
		bit signed [WORD_W-1:0] pos[LANES];
		bit signed [WORD_W-1:0] spin[LANES];
	} particle_t;

	typedef struct {
		particle_t         stim;
		bit                fixed;
		bit                want_alive;
		bit [WORD_W-1:0]   want_age;
	} vector_t;

	typedef struct {
		bit        [STEP_W-1:0] step;
		bit signed [WORD_W-1:0] grav;
		bit        [STEP_W-1:0] drag;
		bit        [STEP_W-1:0] damp;
	} frame_settings_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// age, lifetime, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, spin_x, spin_y, spin_z
	logic [TDATA_W-1:0]   s_axis_tdata;
	// alive
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// age_out, lifetime_out, vel_*_out, pos_*_out, spin_*_out
	logic [TDATA_W-1:0]   m_axis_tdata;
	// alive_out
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	frame_settings_t frame_cfg = '{TIME_STEP_RST, GRAVITY_RST, DRAG_FACTOR_RST, SPIN_DAMPING_RST};
	particle_t expected_particles[$];
	int mismatch_count = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int tx_idle_pct = 31;
	int rx_idle_pct = 83;
	int holds_asked = 0;
	string lane_tag[LANES] = '{"x", "y", "z"};

	vector_t directed_rows[N_DIRECTED] = '{
		// inactive records pass straight through
		'{'{1'b0, 32'hFFFF_FFFF, 32'h0000_0000,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000},
			'{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF}}, 1'b1, 1'b0, 32'hFFFF_FFFF},
		'{'{1'b0, 32'h0000_0000, 32'h0000_0000,
			'{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}},
			1'b1, 1'b0, 32'h0000_0000},
		// new age lands exactly on the lifetime
		'{'{1'b1, 32'h0000_0000, 32'h0000_0419,
			'{32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678},
			'{32'h00A0_0000, 32'hFF60_0000, 32'h0000_0000},
			'{32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF}}, 1'b1, 1'b0, 32'h0000_0419},
		// age saturates, then dies
		'{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			'{32'h1, 32'h2, 32'h3}, '{32'h4, 32'h5, 32'h6}, '{32'h7, 32'h8, 32'h9}},
			1'b1, 1'b0, 32'hFFFF_FFFF},
		'{'{1'b1, 32'hFFFF_FC00, 32'hFFFF_FFFF,
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF}}, 1'b1, 1'b0, 32'hFFFF_FFFF},
		'{'{1'b1, 32'h0005_0000, 32'h0000_0000,
			'{32'h0003_0000, 32'h0004_0000, 32'h0005_0000},
			'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001},
			'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}}, 1'b1, 1'b0, 32'h0005_0419},
		'{'{1'b1, 32'hFFFF_FBE6, 32'hFFFF_FFFF,
			'{32'h0000_0100, 32'h0000_0200, 32'h0000_0300},
			'{32'h0000_0400, 32'h0000_0500, 32'h0000_0600},
			'{32'h0000_0700, 32'h0000_0800, 32'h0000_0900}}, 1'b1, 1'b0, 32'hFFFF_FFFF},
		// survivors from here on
		'{'{1'b1, 32'hFFFF_FBE5, 32'hFFFF_FFFF,
			'{32'h0002_0000, 32'hFFFD_8000, 32'h0000_8000},
			'{32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000},
			'{32'h0003_0000, 32'hFFFE_0000, 32'h0000_0001}}, 1'b0, 1'b0, 32'h0},
		'{'{1'b1, 32'h0000_0000, 32'h0000_041A,
			'{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}},
			1'b0, 1'b0, 32'h0},
		'{'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}}, 1'b0, 1'b0, 32'h0},
		'{'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}}, 1'b0, 1'b0, 32'h0},
		// minus one in every velocity and spin lane: truncation must go toward minus infinity
		'{'{1'b1, 32'h0001_0000, 32'h0002_0000,
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}}, 1'b0, 1'b0, 32'h0},
		'{'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
			'{32'h1, 32'h1, 32'h1},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{32'h1, 32'h1, 32'h1}}, 1'b0, 1'b0, 32'h0},
		'{'{1'b1, 32'h1234_5678, 32'h7FFF_FFFF,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
			'{32'h7FFF_FFF0, 32'h8000_0010, 32'h0000_0000},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000}}, 1'b0, 1'b0, 32'h0}
	};

	debris_particle_update DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit signed [WORD_W-1:0] clamp_s32(longint v);
		if (v > S32_HI)
			return S32_HI[WORD_W-1:0];
		else if (v < S32_LO)
			return S32_LO[WORD_W-1:0];
		return v[WORD_W-1:0];
	endfunction

	function automatic particle_t advance_particle(particle_t p);
		particle_t q;
		longint grown;
		longint fall;
		q = p;
		if (!p.alive)
			return q;
		grown = longint'(p.age) + longint'(frame_cfg.step);
		if (grown > U32_HI)
			grown = U32_HI;
		q.age = grown[WORD_W-1:0];
		if (grown >= longint'(p.lifetime)) begin
			q.alive = 1'b0;
			return q;
		end
		fall = (longint'(frame_cfg.grav) * longint'(frame_cfg.step)) >>> 16;
		q.vel[LANE_Y] = clamp_s32(longint'(p.vel[LANE_Y]) + fall);
		for (int l = 0; l < LANES; l++) begin
			q.vel[l] = clamp_s32((longint'(q.vel[l]) * longint'(frame_cfg.drag)) >>> 15);
			q.spin[l] = clamp_s32((longint'(p.spin[l]) * longint'(frame_cfg.damp)) >>> 15);
			// position moves with the damped velocity
			q.pos[l] = clamp_s32(longint'(p.pos[l]) +
				((longint'(q.vel[l]) * longint'(frame_cfg.step)) >>> 16));
		end
		return q;
	endfunction

	function automatic bit [WORD_W-1:0] random_word();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3, 4: return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic log_mismatch(string msg);
		mismatch_count++;
		$display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic send_particle(particle_t p, particle_t want);
		logic [TDATA_W-1:0] word;
		int gap;
		word = '0;
		word[0 +: WORD_W] = p.age;
		word[WORD_W +: WORD_W] = p.lifetime;
		for (int l = 0; l < LANES; l++) begin
			word[(2 + l) * WORD_W +: WORD_W] = p.vel[l];
			word[(5 + l) * WORD_W +: WORD_W] = p.pos[l];
			word[(8 + l) * WORD_W +: WORD_W] = p.spin[l];
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= p.alive;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_particles.insert(expected_particles.size(), want);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every pending particle has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_particles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [WORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_TIME_STEP:    frame_cfg.step = value[STEP_W-1:0];
			REG_GRAVITY:      frame_cfg.grav = value;
			REG_DRAG_FACTOR:  frame_cfg.drag = value[STEP_W-1:0];
			REG_SPIN_DAMPING: frame_cfg.damp = value[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_settings(bit [STEP_W-1:0] step, bit [WORD_W-1:0] grav,
			bit [STEP_W-1:0] drag, bit [STEP_W-1:0] damp);
		drain();
		write_reg(REG_TIME_STEP, {16'h0, step});
		write_reg(REG_GRAVITY, grav);
		write_reg(REG_DRAG_FACTOR, {16'h0, drag});
		write_reg(REG_SPIN_DAMPING, {16'h0, damp});
		// no such register, must leave the settings alone
		write_reg(REG_UNMAPPED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random backpressure plus one long hold-off on request
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != holds_asked) begin
				holds_seen = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		particle_t got;
		particle_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if ($isunknown({m_axis_tuser, m_axis_tdata}))
				log_mismatch("unknown bits on result");
			got.alive = m_axis_tuser;
			got.age = m_axis_tdata[0 +: WORD_W];
			got.lifetime = m_axis_tdata[WORD_W +: WORD_W];
			for (int l = 0; l < LANES; l++) begin
				got.vel[l] = m_axis_tdata[(2 + l) * WORD_W +: WORD_W];
				got.pos[l] = m_axis_tdata[(5 + l) * WORD_W +: WORD_W];
				got.spin[l] = m_axis_tdata[(8 + l) * WORD_W +: WORD_W];
			end
			if (expected_particles.size() == 0) begin
				log_mismatch("result with no particle pending");
			end else begin
				want = expected_particles.pop_front();
				if (got.alive != want.alive)
					log_mismatch($sformatf("alive_out got %0d want %0d", got.alive, want.alive));
				if (got.age != want.age)
					log_mismatch($sformatf("age_out got %h want %h", got.age, want.age));
				if (got.lifetime != want.lifetime)
					log_mismatch($sformatf("lifetime_out got %h want %h",
						got.lifetime, want.lifetime));
				for (int l = 0; l < LANES; l++) begin
					if (got.vel[l] != want.vel[l])
						log_mismatch($sformatf("vel_%s_out got %h want %h",
							lane_tag[l], got.vel[l], want.vel[l]));
					if (got.pos[l] != want.pos[l])
						log_mismatch($sformatf("pos_%s_out got %h want %h",
							lane_tag[l], got.pos[l], want.pos[l]));
					if (got.spin[l] != want.spin[l])
						log_mismatch($sformatf("spin_%s_out got %h want %h",
							lane_tag[l], got.spin[l], want.spin[l]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		particle_t p;
		particle_t want;
		vector_t row;
		longint reach;
		longint span;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TIME_STEP;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed records against the settings after reset
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.fixed) begin
				want = row.stim;
				want.alive = row.want_alive;
				want.age = row.want_age;
			end else begin
				want = advance_particle(row.stim);
			end
			send_particle(row.stim, want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_settings(16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
				1: program_settings(16'h0000, 32'h8000_0000, 16'h0000, 16'h0000);
				// earth gravity, unity factors
				3: program_settings(16'd1049, 32'hFFF6_30A4, 16'd32768, 16'd32768);
				default: program_settings(16'($urandom_range(65535)), $urandom,
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768)));
			endcase
			case (phase / 3)
				0: begin
					tx_idle_pct = 31;
					rx_idle_pct = 83;
				end
				1: begin
					tx_idle_pct = 83;
					rx_idle_pct = 31;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == 40)
					drain();
				if (phase == 8 && n == 30)
					holds_asked++;
				p.alive = ($urandom_range(99) < 88);
				p.age = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
				for (int l = 0; l < LANES; l++) begin
					p.vel[l] = random_word();
					p.pos[l] = random_word();
					p.spin[l] = random_word();
				end
				reach = longint'(p.age) + longint'(frame_cfg.step);
				case ($urandom_range(9))
					0: span = longint'($urandom) - reach;
					1: span = 0;
					2: span = 1;
					default: span = 1 + longint'($urandom_range(32'h0FFF_FFFF));
				endcase
				// lifetime near or beyond the new age so most records keep moving
				reach = reach + span;
				p.lifetime = (reach > U32_HI) ? 32'hFFFF_FFFF : reach[WORD_W-1:0];
				send_particle(p, advance_particle(p));
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: sim.f
sv/dpu_pkg.sv
sv/dpu_cfg_regs.sv
sv/debris_particle_update.sv
tb/sv/tb_top.sv
